// ----- sv/buffer_level_drift_loop_filter_core_defines.svh -----
// ---------------------------------------------------------------------------
// Buffer level drift loop filter: assertion macros
// Shared property shorthands; they expect clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef BUFFER_LEVEL_DRIFT_LOOP_FILTER_CORE_DEFINES_SVH
`define BUFFER_LEVEL_DRIFT_LOOP_FILTER_CORE_DEFINES_SVH

// cons must hold in the same cycle as ante
`define BLFL_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define BLFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/blfl_pkg.sv -----
// ---------------------------------------------------------------------------
// Buffer level drift loop filter: package
// Field widths, register map, datapath operations and control structs.
// ---------------------------------------------------------------------------
package blfl_pkg;

  // fixed field widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int GAIN_W      = 32;
  localparam int TARGET_W    = 15;
  localparam int DRIFT_LIM_W = 31;
  localparam int Q30_W       = 32;
  localparam int CORR_W      = 31;

  // faststart arithmetic
  localparam int STEP_W     = 16;
  localparam int DEN_W      = 17;
  localparam int NUM_W      = 36;
  localparam int SCALE_W    = 32;
  localparam int RATIO_FRAC = 16;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = 6;
  localparam logic [DEN_W-1:0] BOOST_DIV = 17'd10;

  // register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TARGET_LEVEL     = 3'd0,
    CFG_GAIN_PROP        = 3'd1,
    CFG_GAIN_INTEGRAL    = 3'd2,
    CFG_GAIN_FIRST_POLE  = 3'd3,
    CFG_GAIN_SECOND_POLE = 3'd4,
    CFG_MAX_DRIFT        = 3'd5,
    CFG_INITIAL_DRIFT    = 3'd6,
    CFG_FASTSTART_RATIO  = 3'd7
  } cfg_reg_t;

  // multiply operations, in issue order
  typedef enum logic [2:0] {
    OP_SCALE_P,
    OP_SCALE_1,
    OP_SCALE_2,
    OP_INTEG,
    OP_PROP,
    OP_POLE1,
    OP_POLE2
  } op_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic div_step;
    logic mul_setup;
    logic mul_lo;
    logic mul_hi;
    logic mul_acc;
    logic apply;
    op_t  op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic boost_go;
    logic boost_on;
  } dp_stat_t;

endpackage

// ----- sv/blfl_if.sv -----
// ---------------------------------------------------------------------------
// Buffer level drift loop filter: channel interfaces
// Valid/ready channels for configuration writes, fill levels and results.
// ---------------------------------------------------------------------------

// configuration write channel
interface blfl_cfg_if;
  import blfl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// fill level input channel
interface blfl_level_if #(parameter int LEVEL_WIDTH = 16);
  logic                   valid;
  logic                   ready;
  logic [LEVEL_WIDTH-1:0] fill_level;
  modport source (output valid, output fill_level, input ready);
  modport sink (input valid, input fill_level, output ready);
endinterface

// result channel
interface blfl_result_if;
  import blfl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [Q30_W-1:0]  drift_estimate;
  logic signed [CORR_W-1:0] rate_correction;
  logic                     faststart_active;
  modport source (output valid, output drift_estimate, output rate_correction,
                  output faststart_active, input ready);
  modport sink (input valid, input drift_estimate, input rate_correction,
                input faststart_active, output ready);
endinterface

// ----- sv/blfl_ctrl.sv -----
// ---------------------------------------------------------------------------
// Buffer level drift loop filter: controller
// Sequences one tick: prime/decide, optional divide, multiply ops, output.
// ---------------------------------------------------------------------------
module blfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output blfl_pkg::dp_cmd_t cmd,
  input  blfl_pkg::dp_stat_t stat
);
  import blfl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRIME,
    S_DIV,
    S_SETUP,
    S_LO,
    S_HI,
    S_ACC,
    S_APPLY,
    S_DONE
  } state_t;

  state_t               state;
  op_t                  op;
  op_t                  op_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // following operation
  always_comb begin
    unique case (op)
      OP_SCALE_P: op_next = OP_SCALE_1;
      OP_SCALE_1: op_next = OP_SCALE_2;
      OP_SCALE_2: op_next = OP_INTEG;
      OP_INTEG:   op_next = OP_PROP;
      OP_PROP:    op_next = OP_POLE1;
      OP_POLE1:   op_next = OP_POLE2;
      OP_POLE2:   op_next = OP_POLE2;
      default:    op_next = OP_INTEG;
    endcase
  end

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.start     = (state == S_PRIME);
    cmd.div_step  = (state == S_DIV);
    cmd.mul_setup = (state == S_SETUP);
    cmd.mul_lo    = (state == S_LO);
    cmd.mul_hi    = (state == S_HI);
    cmd.mul_acc   = (state == S_ACC);
    cmd.apply     = (state == S_APPLY);
    cmd.op        = op;
    cmd.load_out  = (state == S_DONE) && out_free;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_INTEG;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a result leaving while the next one loads keeps valid high
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PRIME;
          end
        end
        S_PRIME: begin
          if (stat.boost_go) begin
            state   <= S_DIV;
            div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
            op      <= OP_SCALE_P;
          end else begin
            state <= S_SETUP;
            op    <= OP_INTEG;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_SETUP;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_SETUP: state <= S_LO;
        S_LO:    state <= S_HI;
        S_HI:    state <= S_ACC;
        S_ACC:   state <= S_APPLY;
        S_APPLY: begin
          if (op == OP_POLE2) begin
            state <= S_DONE;
          end else begin
            state <= S_SETUP;
            op    <= op_next;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/blfl_datapath.sv -----
// ---------------------------------------------------------------------------
// Buffer level drift loop filter: datapath
// Config registers, loop state, radix-2 divider and a split multiplier.
// ---------------------------------------------------------------------------
module blfl_datapath #(
  parameter int VALUE_WIDTH = 32,
  parameter int LEVEL_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  blfl_pkg::cfg_reg_t                     cfg_index,
  input  logic [blfl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [LEVEL_WIDTH-1:0]                 fill_level,
  input  blfl_pkg::dp_cmd_t                      cmd,
  output blfl_pkg::dp_stat_t                     stat,
  output logic signed [blfl_pkg::Q30_W-1:0]      drift_estimate,
  output logic signed [blfl_pkg::CORR_W-1:0]     rate_correction,
  output logic                                   faststart_active
);
  import blfl_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int FRAC = VW - 2;
  localparam int DW   = ((TARGET_W > LEVEL_WIDTH) ? TARGET_W : LEVEL_WIDTH) + 1;
  localparam int AW0  = (VW > SCALE_W + 1) ? VW : SCALE_W + 1;
  localparam int AW   = (AW0 > DW) ? AW0 : DW;
  localparam int HW   = GAIN_W / 2;
  localparam int PPW  = AW + HW + 1;
  localparam int PW   = AW + GAIN_W;
  localparam int XW   = VW + Q30_W;
  // Q2.30 <-> Q2.F alignment
  localparam int IN_L = (VW >= Q30_W) ? VW - Q30_W : 0;
  localparam int IN_R = (VW < Q30_W) ? Q30_W - VW : 0;
  // Q.32 product -> Q2.F alignment
  localparam int QX   = 16;
  localparam int EW   = PW + QX;
  localparam int QL   = (FRAC > GAIN_W) ? FRAC - GAIN_W : 0;
  localparam int QR   = (FRAC <= GAIN_W) ? GAIN_W - FRAC : 0;
  localparam int SC_HI = RATIO_FRAC + GAIN_W;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] HALF = {3'b001, {(VW-3){1'b0}}};

  // saturate a wide value to the value range
  function automatic logic signed [VW-1:0] sat_wide(input logic signed [EW-1:0] x);
    logic all_ones;
    logic all_zeros;
    all_ones  = &x[EW-1:VW-1];
    all_zeros = ~|x[EW-1:VW-1];
    if (all_ones || all_zeros) begin
      sat_wide = x[VW-1:0];
    end else if (x[EW-1]) begin
      sat_wide = VMIN;
    end else begin
      sat_wide = VMAX;
    end
  endfunction

  // saturating a + b or a - b
  function automatic logic signed [VW-1:0] sat_sum(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b,
                                                   input logic              sub);
    logic signed [VW:0] s;
    if (sub) begin
      s = {a[VW-1], a} - {b[VW-1], b};
    end else begin
      s = {a[VW-1], a} + {b[VW-1], b};
    end
    if (s[VW] != s[VW-1]) begin
      sat_sum = s[VW] ? VMIN : VMAX;
    end else begin
      sat_sum = s[VW-1:0];
    end
  endfunction

  // symmetric clamp to +-lim, lim >= 0
  function automatic logic signed [VW-1:0] clamp_lim(input logic signed [VW-1:0] v,
                                                     input logic signed [VW-1:0] lim);
    if (v > lim) begin
      clamp_lim = lim;
    end else if (v < -lim) begin
      clamp_lim = -lim;
    end else begin
      clamp_lim = v;
    end
  endfunction

  // configuration registers
  logic [TARGET_W-1:0]           target_level;
  logic [GAIN_W-1:0]             gain_prop;
  logic [GAIN_W-1:0]             gain_integral;
  logic [GAIN_W-1:0]             gain_first_pole;
  logic [GAIN_W-1:0]             gain_second_pole;
  logic [DRIFT_LIM_W-1:0]        max_drift;
  logic signed [Q30_W-1:0]       initial_drift;
  logic [SCALE_W-1:0]            faststart_ratio;

  // loop state
  logic signed [VW-1:0]          drift_value;
  logic signed [VW-1:0]          first_stage;
  logic signed [VW-1:0]          second_stage;
  logic                          boost_on;
  logic [STEP_W-1:0]             boost_steps;
  logic                          primed;

  // working registers
  logic [LEVEL_WIDTH-1:0]        fill_r;
  logic [GAIN_W-1:0]             gp_r;
  logic [GAIN_W-1:0]             g1_r;
  logic [GAIN_W-1:0]             g2_r;
  logic [DEN_W-1:0]              den_r;
  logic [DEN_W-1:0]              rem;
  logic [NUM_W-1:0]              quo;
  logic signed [AW-1:0]          a_r;
  logic [GAIN_W-1:0]             b_r;
  logic signed [PPW-1:0]         pp;
  logic signed [PW-1:0]          acc;
  logic signed [VW-1:0]          t_r;

  // combinational terms
  logic signed [DW-1:0]          diff;
  logic [NUM_W-1:0]              num;
  logic [DEN_W-1:0]              den;
  logic                          boost_cond;
  logic [DEN_W:0]                trial;
  logic                          trial_ge;
  logic signed [XW-1:0]          init_x;
  logic [XW-1:0]                 md_x;
  logic signed [VW-1:0]          init_v;
  logic signed [VW-1:0]          md_v;
  logic signed [EW-1:0]          e_x;
  logic signed [VW-1:0]          qv;
  logic signed [VW-1:0]          mg;
  logic [GAIN_W-1:0]             sc_v;
  logic signed [HW:0]            b_half;
  logic signed [VW-1:0]          corr_v;
  logic signed [XW-1:0]          drift_x;
  logic signed [XW-1:0]          corr_x;

  // error, faststart ratio terms and alignment
  always_comb begin
    diff       = $signed(DW'(target_level)) - $signed(DW'(fill_r));
    num        = NUM_W'({faststart_ratio, 3'b000}) + NUM_W'({faststart_ratio, 1'b0});
    den        = BOOST_DIV + DEN_W'(boost_steps);
    boost_cond = num > NUM_W'({den, {RATIO_FRAC{1'b0}}});
    trial      = {rem, quo[NUM_W-1]};
    trial_ge   = trial >= {1'b0, den_r};
    init_x     = $signed({{VW{initial_drift[Q30_W-1]}}, initial_drift}) <<< IN_L >>> IN_R;
    md_x       = {{(VW+1){1'b0}}, max_drift} << IN_L >> IN_R;
    init_v     = init_x[VW-1:0];
    md_v       = md_x[VW-1:0];
    e_x        = $signed({{QX{acc[PW-1]}}, acc}) <<< QL >>> QR;
    qv         = sat_wide(e_x);
    mg         = acc[VW+GAIN_W-1:GAIN_W];
    sc_v       = (|acc[PW-1:SC_HI]) ? {GAIN_W{1'b1}} : acc[SC_HI-1:RATIO_FRAC];
    b_half     = cmd.mul_hi ? $signed({1'b0, b_r[GAIN_W-1:HW]})
                            : $signed({1'b0, b_r[HW-1:0]});
    corr_v     = clamp_lim(second_stage, HALF);
    drift_x    = $signed({{Q30_W{drift_value[VW-1]}}, drift_value}) <<< IN_R >>> IN_L;
    corr_x     = $signed({{Q30_W{corr_v[VW-1]}}, corr_v}) <<< IN_R >>> IN_L;
  end

  assign stat.boost_go = boost_on && boost_cond;
  assign stat.boost_on = boost_on;

  // control state: config registers and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level     <= 15'd256;
      gain_prop        <= 32'd42949673;
      gain_integral    <= 32'd4294967;
      gain_first_pole  <= 32'd429496730;
      gain_second_pole <= 32'd715827883;
      max_drift        <= 31'd1073742;
      initial_drift    <= '0;
      faststart_ratio  <= 32'd65536;
      drift_value      <= '0;
      first_stage      <= '0;
      second_stage     <= '0;
      boost_on         <= 1'b1;
      boost_steps      <= '0;
      primed           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TARGET_LEVEL:     target_level     <= cfg_data[TARGET_W-1:0];
          CFG_GAIN_PROP:        gain_prop        <= cfg_data;
          CFG_GAIN_INTEGRAL:    gain_integral    <= cfg_data;
          CFG_GAIN_FIRST_POLE:  gain_first_pole  <= cfg_data;
          CFG_GAIN_SECOND_POLE: gain_second_pole <= cfg_data;
          CFG_MAX_DRIFT:        max_drift        <= cfg_data[DRIFT_LIM_W-1:0];
          CFG_INITIAL_DRIFT:    initial_drift    <= cfg_data;
          CFG_FASTSTART_RATIO:  faststart_ratio  <= cfg_data;
        endcase
      end

      // first tick priming and faststart decision
      if (cmd.start) begin
        if (!primed) begin
          drift_value <= clamp_lim(init_v, md_v);
          primed      <= 1'b1;
        end
        if (boost_on) begin
          if (boost_cond) begin
            if (boost_steps != {STEP_W{1'b1}}) begin
              boost_steps <= boost_steps + 1'b1;
            end
          end else begin
            boost_on <= 1'b0;
          end
        end
      end

      // loop updates from the multiplier result
      if (cmd.apply) begin
        case (cmd.op)
          OP_INTEG: drift_value  <= clamp_lim(sat_sum(drift_value, qv, 1'b0), md_v);
          OP_POLE1: first_stage  <= sat_sum(first_stage, mg, 1'b0);
          OP_POLE2: second_stage <= sat_sum(second_stage, mg, 1'b0);
          default: ;
        endcase
      end
    end
  end

  // payload registers: gains, divider, multiplier, outputs
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fill_r <= fill_level;
    end

    if (cmd.start) begin
      gp_r  <= gain_prop;
      g1_r  <= gain_first_pole;
      g2_r  <= gain_second_pole;
      den_r <= den;
      quo   <= num;
      rem   <= '0;
    end

    // restoring divide, one quotient bit a cycle
    if (cmd.div_step) begin
      if (trial_ge) begin
        rem <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], trial_ge};
    end

    // operand select
    if (cmd.mul_setup) begin
      case (cmd.op)
        OP_SCALE_P: begin
          a_r <= AW'(quo[SCALE_W-1:0]);
          b_r <= gain_prop;
        end
        OP_SCALE_1: begin
          a_r <= AW'(quo[SCALE_W-1:0]);
          b_r <= gain_first_pole;
        end
        OP_SCALE_2: begin
          a_r <= AW'(quo[SCALE_W-1:0]);
          b_r <= gain_second_pole;
        end
        OP_INTEG: begin
          a_r <= AW'(diff);
          b_r <= gain_integral;
        end
        OP_PROP: begin
          a_r <= AW'(diff);
          b_r <= gp_r;
        end
        OP_POLE1: begin
          a_r <= AW'(sat_sum(t_r, first_stage, 1'b1));
          b_r <= g1_r;
        end
        OP_POLE2: begin
          a_r <= AW'(sat_sum(first_stage, second_stage, 1'b1));
          b_r <= g2_r;
        end
        default: ;
      endcase
    end

    // two 16-bit halves of the gain through one multiplier
    if (cmd.mul_lo || cmd.mul_hi) begin
      pp <= a_r * b_half;
    end
    if (cmd.mul_hi) begin
      acc <= PW'(pp);
    end
    if (cmd.mul_acc) begin
      acc <= acc + (PW'(pp) <<< HW);
    end

    if (cmd.apply) begin
      case (cmd.op)
        OP_SCALE_P: gp_r <= sc_v;
        OP_SCALE_1: g1_r <= sc_v;
        OP_SCALE_2: g2_r <= sc_v;
        OP_PROP:    t_r  <= sat_sum(qv, drift_value, 1'b0);
        default: ;
      endcase
    end

    if (cmd.load_out) begin
      drift_estimate   <= drift_x[Q30_W-1:0];
      rate_correction  <= corr_x[CORR_W-1:0];
      faststart_active <= boost_on;
    end
  end

endmodule

// ----- sv/buffer_level_drift_loop_filter_core.sv -----
// ---------------------------------------------------------------------------
// Buffer level drift loop filter core
// Each fill level beat runs one PI loop update with a two-pole low-pass and
// returns one result beat: drift estimate in Q2.30, rate correction in Q1.30
// (clamped to +-0.5) and the faststart flag. A tick that applies faststart
// also runs the restoring divider that forms the faststart scale and the
// three multiplications that scale the gains. Each of the four (or seven
// with faststart) multiplications runs on a single shared multiplier that
// processes the gain in two 16-bit halves. One tick is in flight at a time;
// a new fill level beat is taken while the previous result still waits on
// the output. Configuration writes are always accepted and must only be
// issued while the core is idle.
// ---------------------------------------------------------------------------
`include "buffer_level_drift_loop_filter_core_defines.svh"

module buffer_level_drift_loop_filter_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int LEVEL_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  blfl_cfg_if.sink      cfg,
  blfl_level_if.sink    level,
  blfl_result_if.source result
);
  import blfl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  // sequencer
  blfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (level.valid),
    .in_ready  (level.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // arithmetic and state
  blfl_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg.valid && cfg.ready),
    .cfg_index        (cfg_reg_t'(cfg.index)),
    .cfg_data         (cfg.data),
    .fill_level       (level.fill_level),
    .cmd              (cmd),
    .stat             (stat),
    .drift_estimate   (result.drift_estimate),
    .rate_correction  (result.rate_correction),
    .faststart_active (result.faststart_active)
  );

  // faststart never comes back once it has ended
  `BLFL_ASSERT_NEXT(a_boost_sticky, !stat.boost_on, !stat.boost_on, "faststart re-enabled")
  // one tick in flight
  `BLFL_ASSERT_NEXT(a_single_tick, level.valid && level.ready, !level.ready, "second beat taken")
  // correction stays inside +-0.5
  `BLFL_ASSERT_HOLDS(a_corr_bound, result.valid,
    (result.rate_correction <= 31'sd536870912) && (result.rate_correction >= -31'sd536870912),
    "rate correction out of range")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Buffer level drift loop filter: testbench
// Drives register writes and fill level beats into the core with random
// gaps and stalls. A scoreboard class predicts every tick of the PI loop and
// two-pole low-pass in fixed point. It compares each result beat, field by
// field, with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module tb_top;
  import blfl_pkg::*;

  localparam int LEVEL_W         = 16;
  localparam int RANDOM_PHASES   = 10;
  localparam int TICKS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 100;
  localparam int CYCLE_LIMIT     = 2000000;

  localparam longint VAL_MAX  = 64'sd2147483647;
  localparam longint VAL_MIN  = -VAL_MAX - 1;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam int     STEP_MAX = 65535;

  // one full register set
  typedef struct {
    logic [TARGET_W-1:0]    target;
    logic [GAIN_W-1:0]      prop;
    logic [GAIN_W-1:0]      integral;
    logic [GAIN_W-1:0]      pole1;
    logic [GAIN_W-1:0]      pole2;
    logic [DRIFT_LIM_W-1:0] drift_limit;
    logic [Q30_W-1:0]       drift_seed;
    logic [GAIN_W-1:0]      ratio;
  } setup_t;

  // -------------------------------------------------------------------------
  // Scoreboard: tracks the loop state and holds the predicted result beats
  // -------------------------------------------------------------------------
  class drift_loop_scoreboard;
    typedef struct {
      logic signed [Q30_W-1:0]  drift;
      logic signed [CORR_W-1:0] corr;
      logic                     boost;
    } tick_result_t;

    // register copy
    bit [TARGET_W-1:0]       target;
    bit [GAIN_W-1:0]         g_prop, g_int, g_pole1, g_pole2, ratio;
    bit [DRIFT_LIM_W-1:0]    drift_limit;
    bit signed [Q30_W-1:0]   drift_seed;
    // loop state
    longint                  drift, stage1, stage2;
    bit                      boost_on, primed;
    int unsigned             boost_steps;
    tick_result_t            pending_results[$];
    int                      errors;

    function new();
      target      = 15'd256;
      g_prop      = 32'd42949673;
      g_int       = 32'd4294967;
      g_pole1     = 32'd429496730;
      g_pole2     = 32'd715827883;
      drift_limit = 31'd1073742;
      drift_seed  = '0;
      ratio       = 32'd65536;
      drift       = 0;
      stage1      = 0;
      stage2      = 0;
      boost_on    = 1'b1;
      primed      = 1'b0;
      boost_steps = 0;
      errors      = 0;
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_TARGET_LEVEL:     target = d[TARGET_W-1:0];
        CFG_GAIN_PROP:        g_prop = d;
        CFG_GAIN_INTEGRAL:    g_int = d;
        CFG_GAIN_FIRST_POLE:  g_pole1 = d;
        CFG_GAIN_SECOND_POLE: g_pole2 = d;
        CFG_MAX_DRIFT:        drift_limit = d[DRIFT_LIM_W-1:0];
        CFG_INITIAL_DRIFT:    drift_seed = d;
        CFG_FASTSTART_RATIO:  ratio = d;
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
    endfunction

    function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // error times a Q0.32 gain, floored into Q2.30
    function longint gain_to_val(longint p);
      return sat(p >>> 2);
    endfunction

    // floor(v * g / 2^32), split so the low half stays unsigned
    function longint mul_gain(longint v, bit [GAIN_W-1:0] g);
      bit [63:0] lo_prod;
      longint    hi;
      hi = v >>> 32;
      lo_prod = {32'b0, v[31:0]} * {32'b0, g};
      return hi * longint'({32'b0, g}) + longint'(lo_prod >> 32);
    endfunction

    // gain times a Q16.16 scale, saturated to 32 bits
    function bit [GAIN_W-1:0] scale_gain(bit [GAIN_W-1:0] g, bit [63:0] s16);
      bit [63:0] r;
      r = {32'b0, g} * (s16 >> 16) + (({32'b0, g} * {48'b0, s16[15:0]}) >> 16);
      return (r > 64'hFFFF_FFFF) ? '1 : r[GAIN_W-1:0];
    endfunction

    // one loop tick for an accepted fill level beat
    function void note_fill(bit [LEVEL_W-1:0] fill);
      longint          diff, limit, t;
      bit [GAIN_W-1:0] gp, g1, g2;
      bit [63:0]       num, den, s16;
      tick_result_t    r;
      limit = longint'({33'b0, drift_limit});
      diff  = longint'({49'b0, target}) - longint'({48'b0, fill});
      gp = g_prop;
      g1 = g_pole1;
      g2 = g_pole2;

      // first tick seeds the drift
      if (!primed) begin
        drift  = clamp(longint'(drift_seed), limit);
        primed = 1'b1;
      end

      // faststart: scale up while ratio*10/(10+steps) exceeds one
      if (boost_on) begin
        num = {32'b0, ratio} * 64'd10;
        den = 64'd10 + boost_steps;
        if (num > (den << 16)) begin
          s16 = num / den;
          gp  = scale_gain(g_prop, s16);
          g1  = scale_gain(g_pole1, s16);
          g2  = scale_gain(g_pole2, s16);
          if (boost_steps < STEP_MAX) boost_steps++;
        end else begin
          boost_on = 1'b0;
        end
      end

      // integrator, then the two low-pass stages
      drift  = clamp(sat(drift + gain_to_val(diff * longint'({32'b0, g_int}))), limit);
      t      = sat(sat(gain_to_val(diff * longint'({32'b0, gp})) + drift) - stage1);
      stage1 = sat(stage1 + mul_gain(t, g1));
      t      = sat(stage1 - stage2);
      stage2 = sat(stage2 + mul_gain(t, g2));

      t       = clamp(stage2, HALF_Q30);
      r.drift = drift[Q30_W-1:0];
      r.corr  = t[CORR_W-1:0];
      r.boost = boost_on;
      pending_results.push_back(r);
    endfunction

    task check_result(logic signed [Q30_W-1:0] d, logic signed [CORR_W-1:0] c,
                      logic f);
      tick_result_t e;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with no tick pending (drift %0d)", d));
        return;
      end
      e = pending_results.pop_front();
      if (d !== e.drift)
        flag_mismatch($sformatf("drift_estimate %0d, want %0d", d, e.drift));
      if (c !== e.corr)
        flag_mismatch($sformatf("rate_correction %0d, want %0d", c, e.corr));
      if (f !== e.boost)
        flag_mismatch($sformatf("faststart_active %0b, want %0b", f, e.boost));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels and the core
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  int unsigned cycles = 0;
  bit          steady = 1'b0;   // phase without gaps or stalls
  int          ready_hold = 0;

  drift_loop_scoreboard sb = new();

  blfl_cfg_if                          cfg_bus();
  blfl_level_if #(.LEVEL_WIDTH(LEVEL_W)) level_bus();
  blfl_result_if                       result_bus();

  buffer_level_drift_loop_filter_core #(
    .VALUE_WIDTH(32),
    .LEVEL_WIDTH(LEVEL_W)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .level (level_bus),
    .result(result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // beat monitor: register writes, fill levels and results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready)
        sb.write_reg(cfg_reg_t'(cfg_bus.index), cfg_bus.data);
      if (result_bus.valid && result_bus.ready)
        sb.check_result(result_bus.drift_estimate, result_bus.rate_correction,
                        result_bus.faststart_active);
      if (level_bus.valid && level_bus.ready)
        sb.note_fill(level_bus.fill_level);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side stalls
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        result_bus.ready = 1'b0;
        ready_hold--;
      end else begin
        result_bus.ready = 1'b1;
        ready_hold = idle_gap();
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom >> $urandom_range(0, 26);
  endfunction

  // mostly near the target, sometimes far off or at the rails
  function automatic logic [LEVEL_W-1:0] pick_fill(int target);
    int r, off, lvl;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      off = $urandom_range(0, 40);
      lvl = $urandom_range(0, 1) ? target + off : target - off;
    end else if (r < 8) begin
      lvl = $urandom_range(0, 65535);
    end else if (r == 8) begin
      lvl = $urandom_range(0, 1) ? 65535 : 0;
    end else begin
      off = $urandom_range(0, 4000);
      lvl = $urandom_range(0, 1) ? target + off : target - off;
    end
    if (lvl < 0) lvl = 0;
    return lvl[LEVEL_W-1:0];
  endfunction

  function automatic setup_t random_setup(logic [GAIN_W-1:0] ratio);
    setup_t s;
    int     r;
    r = $urandom_range(0, 5);
    s.target = (r == 0) ? '0 : (r == 1) ? '1 :
               (r == 2) ? TARGET_W'($urandom_range(0, 32767))
                        : TARGET_W'($urandom_range(0, 2048));
    s.prop     = pick_gain();
    s.integral = pick_gain();
    s.pole1    = pick_gain();
    s.pole2    = pick_gain();
    r = $urandom_range(0, 7);
    s.drift_limit = (r == 0) ? '0 : (r == 1) ? '1 :
                    DRIFT_LIM_W'($urandom >> $urandom_range(1, 12));
    s.drift_seed  = $urandom;
    s.ratio       = ratio;
    return s;
  endfunction

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  // writes every register back to back, then releases the channel
  task automatic load_setup(setup_t s);
    write_cfg(CFG_TARGET_LEVEL, {17'b0, s.target});
    write_cfg(CFG_GAIN_PROP, s.prop);
    write_cfg(CFG_GAIN_INTEGRAL, s.integral);
    write_cfg(CFG_GAIN_FIRST_POLE, s.pole1);
    write_cfg(CFG_GAIN_SECOND_POLE, s.pole2);
    write_cfg(CFG_MAX_DRIFT, {1'b0, s.drift_limit});
    write_cfg(CFG_INITIAL_DRIFT, s.drift_seed);
    write_cfg(CFG_FASTSTART_RATIO, s.ratio);
    cfg_bus.valid = 1'b0;
  endtask

  // valid stays up across back-to-back beats
  task automatic send_fill(logic [LEVEL_W-1:0] fill);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      level_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    level_bus.valid      = 1'b1;
    level_bus.fill_level = fill;
    do @(posedge clk); while (!level_bus.ready);
    @(negedge clk);
  endtask

  // wait for every predicted beat, then let the core settle
  task automatic drain();
    level_bus.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    setup_t           s;
    logic [GAIN_W-1:0] ratio;
    logic [LEVEL_W-1:0] edge_fills [7];

    rst                  = 1'b1;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_TARGET_LEVEL;
    cfg_bus.data         = '0;
    level_bus.valid      = 1'b0;
    level_bus.fill_level = '0;
    edge_fills = '{16'd0, 16'hFFFF, 16'd256, 16'd257, 16'd255, 16'h5555, 16'hAAAA};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // widest faststart ratio; first tick seeds a clamped extreme drift
    s = '{target: 15'd256, prop: pick_gain(), integral: pick_gain(),
          pole1: pick_gain(), pole2: pick_gain(), drift_limit: 31'h0010_0000,
          drift_seed: ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000),
          ratio: 32'hFFFF_FFFF};
    load_setup(s);
    foreach (edge_fills[i]) send_fill(edge_fills[i]);
    drain();

    // zero target, full gains, drift pinned at zero
    s = '{target: '0, prop: '1, integral: '1, pole1: '1, pole2: '1,
          drift_limit: '0, drift_seed: $urandom, ratio: 32'hFFFF_FFFF};
    load_setup(s);
    send_fill(16'hFFFF);
    send_fill(16'h0000);
    send_fill(16'hFFFF);
    drain();

    // full-scale target, zero gains, widest drift clamp
    s = '{target: '1, prop: '0, integral: '0, pole1: '0, pole2: '0,
          drift_limit: '1, drift_seed: $urandom, ratio: 32'hFFFF_FFFF};
    load_setup(s);
    send_fill(16'h0000);
    send_fill(16'hFFFF);
    send_fill(16'h7FFF);
    drain();

    // random phases; the first ratio of 10.0 lets faststart run out mid-phase
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) ratio = 32'h000A_0000;
      else if (phase == 1) ratio = '0;
      else if (phase == 2) ratio = '1;
      else ratio = $urandom;
      s = random_setup(ratio);
      steady = ($urandom_range(0, 3) == 0);
      load_setup(s);
      repeat (TICKS_PER_PHASE) send_fill(pick_fill(int'(s.target)));
      drain();
      steady = 1'b0;
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- buffer_level_drift_loop_filter_core.f -----
+incdir+sv
sv/blfl_pkg.sv
sv/blfl_if.sv
sv/blfl_ctrl.sv
sv/blfl_datapath.sv
sv/buffer_level_drift_loop_filter_core.sv
tb/tb_top.sv
